FILE: rtl/core/key_gesture_debouncer_assert.svh
// Assertion macros for the key gesture debouncer.
// Included by the top level; no dependencies.
`ifndef KEY_GESTURE_DEBOUNCER_ASSERT_SVH
`define KEY_GESTURE_DEBOUNCER_ASSERT_SVH

// same-cycle implication, checked on every rising clock outside reset
`define KGD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kgd assertion failed");

// next-cycle implication
`define KGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kgd assertion failed");

`endif

FILE: rtl/core/kgd_pkg.sv
// Shared types and constants for the key gesture debouncer.
// No dependencies.
package kgd_pkg;

   localparam int TICK_BITS = 16;
   localparam int EVENT_BITS = 3;
   localparam int TAP_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [EVENT_BITS-1:0] EV_NONE = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_LONG = 3'd4;
   localparam logic [EVENT_BITS-1:0] EV_LONG_RELEASED = 3'd5;
   localparam logic [EVENT_BITS-1:0] EV_LAST = 3'd5;

   localparam logic [TAP_BITS-1:0] TAP_MAX = 4'd15;
   localparam logic [TAP_BITS-1:0] TAP_REPORT_MAX = 4'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_TICKS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_WINDOW_TICKS = 2'd3;

   localparam logic [TICK_BITS-1:0] DEBOUNCE_TICKS_RST = 16'd2;
   localparam logic [TICK_BITS-1:0] LONG_PRESS_TICKS_RST = 16'd100;
   localparam logic [TICK_BITS-1:0] TAP_WINDOW_TICKS_RST = 16'd30;

   typedef struct packed {
      logic active_level;
      logic [TICK_BITS-1:0] debounce_ticks;
      logic [TICK_BITS-1:0] long_press_ticks;
      logic [TICK_BITS-1:0] tap_window_ticks;
   } kgd_cfg_type;

   // one scan tick handed to the gesture core
   typedef struct packed {
      logic step;
      logic pressed;
   } kgd_tick_type;

endpackage

FILE: rtl/core/kgd_req_if.sv
// Request channel: one sampled pin level per transfer.
// No dependencies.
interface kgd_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

FILE: rtl/core/kgd_rsp_if.sv
// Response channel: one event code per transfer.
// Depends on kgd_pkg for the event width.
interface kgd_rsp_if;
   logic valid;
   logic ready;
   logic [kgd_pkg::EVENT_BITS-1:0] event_code;

   modport source (output valid, output event_code, input ready);
   modport sink (input valid, input event_code, output ready);
endinterface

FILE: rtl/core/kgd_gesture_core.sv
// Gesture state: debounce, hold, tap count and tap window counters.
// Depends on kgd_pkg.
module kgd_gesture_core #(
   parameter int COUNTER_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  kgd_pkg::kgd_cfg_type cfg,
   input  kgd_pkg::kgd_tick_type tick,
   output logic [kgd_pkg::EVENT_BITS-1:0] event_code
);
   import kgd_pkg::*;

   localparam int CMP_BITS = (COUNTER_BITS > TICK_BITS) ? COUNTER_BITS : TICK_BITS;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_DEBOUNCED = 2'd1;
   localparam logic [1:0] PHASE_LONG = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] debounce_ff, debounce_in;
   logic [COUNTER_BITS-1:0] hold_ff, hold_in;
   logic [TAP_BITS-1:0] taps_ff, taps_in;
   logic [COUNTER_BITS-1:0] timer_ff, timer_in;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   always_comb begin
      logic [1:0] phase_nx;
      logic [COUNTER_BITS-1:0] debounce_nx;
      logic [COUNTER_BITS-1:0] hold_nx;
      logic [TAP_BITS-1:0] taps_nx;

      phase_in = phase_ff;
      debounce_in = debounce_ff;
      hold_in = hold_ff;
      taps_in = taps_ff;
      timer_in = timer_ff;
      event_code = EV_NONE;
      phase_nx = phase_ff;
      debounce_nx = debounce_ff;
      hold_nx = hold_ff;
      taps_nx = taps_ff;

      if (tick.step) begin
         if (tick.pressed) begin
            if (phase_ff == PHASE_IDLE) begin
               debounce_nx = sat_inc(debounce_ff);
            end
            debounce_in = debounce_nx;
            if (CMP_BITS'(debounce_nx) >= CMP_BITS'(cfg.debounce_ticks)) begin
               if (phase_nx == PHASE_IDLE) begin
                  phase_nx = PHASE_DEBOUNCED;
               end
               if (phase_nx == PHASE_DEBOUNCED) begin
                  hold_nx = sat_inc(hold_ff);
                  hold_in = hold_nx;
                  if (CMP_BITS'(hold_nx) >= CMP_BITS'(cfg.long_press_ticks)) begin
                     phase_nx = PHASE_LONG;
                     event_code = EV_LONG;
                  end
               end
            end
            phase_in = phase_nx;
         end else begin
            debounce_in = '0;
            hold_in = '0;
            if (phase_ff == PHASE_DEBOUNCED && taps_ff != TAP_MAX) begin
               taps_nx = taps_ff + 1'b1;
            end
            taps_in = taps_nx;
            if (taps_nx != '0) begin
               // window expired: report one to three taps, drop anything more
               if (CMP_BITS'(timer_ff) >= CMP_BITS'(cfg.tap_window_ticks)) begin
                  event_code = (taps_nx <= TAP_REPORT_MAX) ? EVENT_BITS'(taps_nx) : EV_NONE;
                  taps_in = '0;
                  timer_in = '0;
               end else begin
                  timer_in = sat_inc(timer_ff);
               end
            end else if (phase_ff == PHASE_LONG) begin
               event_code = EV_LONG_RELEASED;
            end
            phase_in = PHASE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         debounce_ff <= '0;
         hold_ff <= '0;
         taps_ff <= '0;
         timer_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         debounce_ff <= debounce_in;
         hold_ff <= hold_in;
         taps_ff <= taps_in;
         timer_ff <= timer_in;
      end
   end

endmodule

FILE: rtl/core/key_gesture_debouncer.sv
// Key gesture debouncer top level: tap, multi-tap and long-press events.
// Pipeline: a request transfer is captured in the input reg, then its event code in the result reg.
// Throughput: one tick per cycle while the response channel is not stalled; the gesture state updates in a single pass.
// Reset: synchronous; clears counters, pipeline valids, and loads register defaults.
// Depends on kgd_pkg, kgd_req_if, kgd_rsp_if, kgd_gesture_core and the assert header.
`include "key_gesture_debouncer_assert.svh"

module key_gesture_debouncer #(
   parameter int COUNTER_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   kgd_req_if.sink req_ch,
   kgd_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic [kgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kgd_pkg::TICK_BITS-1:0] csr_wdata
);
   import kgd_pkg::*;

   kgd_cfg_type cfg_ff;
   logic in_valid_ff;
   logic pin_ff;
   logic out_valid_ff;
   logic [EVENT_BITS-1:0] code_ff;
   logic out_load;
   kgd_tick_type tick;
   logic [EVENT_BITS-1:0] core_event;

   // result register takes a new code when empty or being drained
   assign out_load = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || out_load;

   assign tick.step = in_valid_ff && out_load;
   assign tick.pressed = (pin_ff == cfg_ff.active_level);

   kgd_gesture_core #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .tick(tick),
      .event_code(core_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level <= 1'b0;
         cfg_ff.debounce_ticks <= DEBOUNCE_TICKS_RST;
         cfg_ff.long_press_ticks <= LONG_PRESS_TICKS_RST;
         cfg_ff.tap_window_ticks <= TAP_WINDOW_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL: cfg_ff.active_level <= csr_wdata[0];
            CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_wdata;
            CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            CSR_TAP_WINDOW_TICKS: cfg_ff.tap_window_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         pin_ff <= req_ch.pin_level;
      end
      if (tick.step) begin
         code_ff <= core_event;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.event_code = code_ff;

   `KGD_ASSERT_NEXT(a_step_fills_result, clock, reset, tick.step, out_valid_ff)
   `KGD_ASSERT_NOW(a_code_range, clock, reset, out_valid_ff, code_ff <= EV_LAST)
   `KGD_ASSERT_NOW(a_held_tick_events, clock, reset, tick.step && tick.pressed,
      core_event == EV_NONE || core_event == EV_LONG)
   `KGD_ASSERT_NOW(a_idle_core_silent, clock, reset, !tick.step, core_event == EV_NONE)

endmodule
